@@ src/acv_pkg.sv @@
// ---------------------------------------------------------------------------
// acv_pkg
// Shared constants, types and the magic text table for the archive
// container validator.
// ---------------------------------------------------------------------------
package acv_pkg;

   // entry counter width (counter saturates at all ones)
   localparam int COUNT_BITS = 16;

   // framing lengths
   localparam int FILE_HDR_LEN  = 21;
   localparam int MAGIC_LEN     = 9;
   localparam int ENTRY_HDR_LEN = 16;

   // reset value of the version limit register
   localparam logic [31:0] MAX_VERSION_RESET = 32'd1;

   // line feed closes the magic text and every entry name
   localparam logic [7:0] LINE_FEED = 8'h0A;

   // error classes
   localparam logic [2:0] ERR_NONE    = 3'd0;
   localparam logic [2:0] ERR_HEADER  = 3'd1;
   localparam logic [2:0] ERR_VERSION = 3'd2;
   localparam logic [2:0] ERR_ENTRY   = 3'd3;
   localparam logic [2:0] ERR_TRUNC   = 3'd4;

   // one accepted stream byte
   typedef struct packed {
      logic [7:0] data_byte;
      logic       last_byte;
   } step_type;

   // end-of-stream verdict
   typedef struct packed {
      logic        stream_ok;
      logic [2:0]  error_class;
      logic [15:0] entries_seen;
   } result_type;

   // expected magic text, one byte per header position
   function automatic logic [7:0] magic_byte(input logic [3:0] idx);
      logic [7:0] value;
      unique case (idx)
         4'd0: value = 8'h50;
         4'd1: value = 8'h4A;
         4'd2: value = 8'h6F;
         4'd3: value = 8'h62;
         4'd4: value = 8'h46;
         4'd5: value = 8'h69;
         4'd6: value = 8'h6C;
         4'd7: value = 8'h65;
         4'd8: value = LINE_FEED;
         default: value = 8'h00;
      endcase
      return value;
   endfunction

endpackage

@@ src/acv_parser.sv @@
// ---------------------------------------------------------------------------
// acv_parser
// Framing state of one container stream. Each step consumes one byte,
// updates the header, name, entry header and data tracking, and on the
// final byte produces the verdict and clears the stream state.
// ---------------------------------------------------------------------------
module acv_parser
   import acv_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        step_en,
   input  step_type    step,
   input  logic [31:0] max_version,
   output result_type  result
);

   localparam logic [1:0] PH_HEADER = 2'd0;
   localparam logic [1:0] PH_NAME   = 2'd1;
   localparam logic [1:0] PH_EHDR   = 2'd2;
   localparam logic [1:0] PH_DATA   = 2'd3;

   localparam logic [COUNT_BITS-1:0] CNT_MAX = {COUNT_BITS{1'b1}};

   logic [1:0]            phase_ff,   phase_in;
   logic [4:0]            hdr_idx_ff, hdr_idx_in;
   logic [31:0]           ver_ff,     ver_in;
   logic                  name_ff,    name_in;
   logic [3:0]            ehi_ff,     ehi_in;
   logic [31:0]           psize_ff,   psize_in;
   logic [31:0]           rem_ff,     rem_in;
   logic [2:0]            err_ff,     err_in;
   logic [COUNT_BITS-1:0] cnt_ff,     cnt_in;

   logic [COUNT_BITS-1:0] cnt_inc;
   logic [31:0]           rem_dec;
   logic [2:0]            cls;

   // saturating increment and data countdown
   assign cnt_inc = (cnt_ff != CNT_MAX) ? cnt_ff + 1'b1 : cnt_ff;
   assign rem_dec = (rem_ff != 32'd0) ? rem_ff - 32'd1 : rem_ff;

   // next stream state and verdict
   always_comb begin
      phase_in   = phase_ff;
      hdr_idx_in = hdr_idx_ff;
      ver_in     = ver_ff;
      name_in    = name_ff;
      ehi_in     = ehi_ff;
      psize_in   = psize_ff;
      rem_in     = rem_ff;
      err_in     = err_ff;
      cnt_in     = cnt_ff;
      cls        = ERR_NONE;
      result     = '0;

      if (step_en) begin
         if (err_ff == ERR_NONE) begin
            unique case (phase_ff)
               PH_HEADER: begin
                  // magic text, then version bytes little-endian
                  if (hdr_idx_ff < 5'(MAGIC_LEN)) begin
                     if (step.data_byte != magic_byte(hdr_idx_ff[3:0])) begin
                        err_in = ERR_HEADER;
                     end
                  end else begin
                     case (hdr_idx_ff)
                        5'(MAGIC_LEN):     ver_in[7:0]   = ver_ff[7:0]   | step.data_byte;
                        5'(MAGIC_LEN + 1): ver_in[15:8]  = ver_ff[15:8]  | step.data_byte;
                        5'(MAGIC_LEN + 2): ver_in[23:16] = ver_ff[23:16] | step.data_byte;
                        5'(MAGIC_LEN + 3): ver_in[31:24] = ver_ff[31:24] | step.data_byte;
                        default: ;
                     endcase
                  end
                  // header complete: check version
                  if (err_in == ERR_NONE) begin
                     if (hdr_idx_ff >= 5'(FILE_HDR_LEN - 1)) begin
                        if (ver_ff > max_version) begin
                           err_in = ERR_VERSION;
                        end else begin
                           phase_in = PH_NAME;
                           name_in  = 1'b0;
                        end
                     end else begin
                        hdr_idx_in = hdr_idx_ff + 5'd1;
                     end
                  end
               end
               PH_NAME: begin
                  // name runs to line feed, must not be empty
                  if (step.data_byte == LINE_FEED) begin
                     if (!name_ff) begin
                        err_in = ERR_ENTRY;
                     end else begin
                        phase_in = PH_EHDR;
                        ehi_in   = 4'd0;
                        psize_in = 32'd0;
                     end
                  end else begin
                     name_in = 1'b1;
                  end
               end
               PH_EHDR: begin
                  // last four entry header bytes hold the packed size
                  case (ehi_ff)
                     4'(ENTRY_HDR_LEN - 4): psize_in[7:0]   = psize_ff[7:0]   | step.data_byte;
                     4'(ENTRY_HDR_LEN - 3): psize_in[15:8]  = psize_ff[15:8]  | step.data_byte;
                     4'(ENTRY_HDR_LEN - 2): psize_in[23:16] = psize_ff[23:16] | step.data_byte;
                     4'(ENTRY_HDR_LEN - 1): psize_in[31:24] = psize_ff[31:24] | step.data_byte;
                     default: ;
                  endcase
                  if (ehi_ff == 4'(ENTRY_HDR_LEN - 1)) begin
                     rem_in = psize_in;
                     if (psize_in == 32'd0) begin
                        cnt_in   = cnt_inc;
                        phase_in = PH_NAME;
                        name_in  = 1'b0;
                     end else begin
                        phase_in = PH_DATA;
                     end
                  end else begin
                     ehi_in = ehi_ff + 4'd1;
                  end
               end
               PH_DATA: begin
                  // count down payload bytes
                  rem_in = rem_dec;
                  if (rem_dec == 32'd0) begin
                     cnt_in   = cnt_inc;
                     phase_in = PH_NAME;
                     name_in  = 1'b0;
                  end
               end
               default: ;
            endcase
         end

         // final byte: verdict, then start over
         if (step.last_byte) begin
            cls = err_in;
            if (err_in == ERR_NONE) begin
               unique case (phase_in)
                  PH_HEADER: cls = ERR_HEADER;
                  PH_NAME:   cls = name_in ? ERR_ENTRY : ERR_NONE;
                  PH_EHDR:   cls = ERR_ENTRY;
                  PH_DATA:   cls = ERR_TRUNC;
                  default:   cls = ERR_TRUNC;
               endcase
            end
            result.stream_ok    = (cls == ERR_NONE);
            result.error_class  = cls;
            result.entries_seen = 16'(cnt_in);

            phase_in   = PH_HEADER;
            hdr_idx_in = 5'd0;
            ver_in     = 32'd0;
            name_in    = 1'b0;
            ehi_in     = 4'd0;
            psize_in   = 32'd0;
            rem_in     = 32'd0;
            err_in     = ERR_NONE;
            cnt_in     = '0;
         end
      end
   end

   // stream state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff   <= PH_HEADER;
         hdr_idx_ff <= 5'd0;
         ver_ff     <= 32'd0;
         name_ff    <= 1'b0;
         ehi_ff     <= 4'd0;
         psize_ff   <= 32'd0;
         rem_ff     <= 32'd0;
         err_ff     <= ERR_NONE;
         cnt_ff     <= '0;
      end else begin
         phase_ff   <= phase_in;
         hdr_idx_ff <= hdr_idx_in;
         ver_ff     <= ver_in;
         name_ff    <= name_in;
         ehi_ff     <= ehi_in;
         psize_ff   <= psize_in;
         rem_ff     <= rem_in;
         err_ff     <= err_in;
         cnt_ff     <= cnt_in;
      end
   end

`ifndef NO_ASSERTIONS
   // the final byte leaves a fresh stream behind
   a_clear_after_last: assert property (@(posedge clock) disable iff (reset)
      step_en && step.last_byte |=> phase_ff == PH_HEADER && hdr_idx_ff == 5'd0
         && err_ff == ERR_NONE && cnt_ff == '0)
      else $error("stream state not cleared after final byte");

   // payload phase always has bytes left to take
   a_data_nonzero: assert property (@(posedge clock) disable iff (reset)
      phase_ff == PH_DATA |-> rem_ff != 32'd0)
      else $error("payload phase with zero bytes remaining");

   // an error holds until the stream ends
   a_error_sticky: assert property (@(posedge clock) disable iff (reset)
      err_ff != ERR_NONE && !(step_en && step.last_byte) |=> $stable(err_ff))
      else $error("error class changed before end of stream");
`endif

endmodule

@@ src/archive_container_validator.sv @@
// ---------------------------------------------------------------------------
// archive_container_validator
// Top level: input register, framing parser, result register and the
// version limit register.
// ---------------------------------------------------------------------------
// Checks the framing of an archive container stream at one byte per clock
// unless stalled. A byte is taken whenever the input register is empty or
// moving on; a byte marked last yields one verdict (valid flag, error class,
// complete entry count) via the input and result registers, and the next
// stream may follow directly. The input only stalls when a final byte waits
// behind a verdict that the result side has not yet taken. Write csr_wr_data
// to set the highest accepted version (reset value 1) between streams only.
module archive_container_validator
   import acv_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   // input channel
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_data_byte,
   input  logic        req_last_byte,
   // result channel
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic        rsp_stream_ok,
   output logic [2:0]  rsp_error_class,
   output logic [15:0] rsp_entries_seen,
   // configuration
   input  logic        csr_wr_en,
   input  logic [31:0] csr_wr_data
);

   logic        in_valid_ff,  in_valid_in;
   step_type    in_step_ff;
   logic        out_valid_ff, out_valid_in;
   result_type  out_res_ff;
   logic [31:0] max_version_ff;

   logic        accept;
   logic        advance;
   result_type  result;

   // held byte moves on unless its verdict has nowhere to go
   assign advance   = in_valid_ff && (!in_step_ff.last_byte || !out_valid_ff || !rsp_stall);
   assign req_stall = in_valid_ff && !advance;
   assign accept    = req_valid && !req_stall;

   assign in_valid_in  = accept || (in_valid_ff && !advance);
   assign out_valid_in = (advance && in_step_ff.last_byte) || (out_valid_ff && rsp_stall);

   // input register
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
      if (accept) begin
         in_step_ff.data_byte <= req_data_byte;
         in_step_ff.last_byte <= req_last_byte;
      end
   end

   // framing state and verdict
   acv_parser u_parser (
      .clock       (clock),
      .reset       (reset),
      .step_en     (advance),
      .step        (in_step_ff),
      .max_version (max_version_ff),
      .result      (result)
   );

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
      end
      if (advance && in_step_ff.last_byte) begin
         out_res_ff <= result;
      end
   end

   // version limit register
   always_ff @(posedge clock) begin
      if (reset) begin
         max_version_ff <= MAX_VERSION_RESET;
      end else if (csr_wr_en) begin
         max_version_ff <= csr_wr_data;
      end
   end

   assign rsp_valid        = out_valid_ff;
   assign rsp_stream_ok    = out_res_ff.stream_ok;
   assign rsp_error_class  = out_res_ff.error_class;
   assign rsp_entries_seen = out_res_ff.entries_seen;

`ifndef NO_ASSERTIONS
   // stall only for a final byte blocked by an untaken verdict
   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> in_step_ff.last_byte && out_valid_ff && rsp_stall)
      else $error("input stalled without a blocked verdict");

   // a final byte that moves on always yields a verdict
   a_last_gives_result: assert property (@(posedge clock) disable iff (reset)
      advance && in_step_ff.last_byte |=> rsp_valid)
      else $error("final byte produced no verdict");

   // a stalled verdict stays put
   a_result_held: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_stream_ok)
         && $stable(rsp_error_class) && $stable(rsp_entries_seen))
      else $error("verdict changed while stalled");
`endif

endmodule

@@ dv/tb.sv @@
// ----------------------------------------------------------------------------
// tb: archive container validator testbench
// Feeds container byte streams through the request channel and checks every
// end-of-stream verdict against a cycle-free predictor of the framing rules.
// A directed set of streams covers each error class and boundary. Random
// streams follow: well formed ones with random content, and others that are
// truncated, corrupted, too new, cut off in a name or noise, under several
// version limits. Both channels see random gaps and stalls.
// ----------------------------------------------------------------------------
module tb;
   import acv_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int RUN_LIMIT = 400000;
   localparam int REPORT_MAX = 10;
   localparam int PHASE_BYTES = 80;
   localparam int PHASE_STREAMS = 1;

   // magic text at the head of every container
   localparam logic [7:0] SIG_TEXT [MAGIC_LEN] = '{
      8'h50, 8'h4A, 8'h6F, 8'h62, 8'h46, 8'h69, 8'h6C, 8'h65, 8'h0A
   };

   // where the parser stands within the stream
   typedef enum logic [1:0] {
      IN_FILE_HDR,
      IN_NAME,
      IN_ENTRY_HDR,
      IN_DATA
   } frame_seg_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [7:0]  req_data_byte = 8'h00;
   logic        req_last_byte = 1'b0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic        rsp_stream_ok;
   logic [2:0]  rsp_error_class;
   logic [15:0] rsp_entries_seen;
   logic        csr_wr_en = 1'b0;
   logic [31:0] csr_wr_data = 32'h0;

   // predictor state
   logic [31:0]           ver_limit = MAX_VERSION_RESET;
   frame_seg_type         seg;
   int unsigned           hdr_pos;
   logic [31:0]           ver_acc;
   logic                  name_open;
   int unsigned           ehdr_pos;
   logic [31:0]           size_acc;
   logic [31:0]           data_left;
   logic [2:0]            err_code;
   logic [COUNT_BITS-1:0] entry_cnt;

   // stimulus and scoreboard storage
   step_type    pending_q[$];
   result_type  verdict_q[$];
   logic [7:0]  frame_buf[$];
   step_type    next_step;
   logic        req_fire = 1'b0;
   int          send_gap = 0;
   int          stall_left = 0;
   bit          quiet_send = 1'b0;
   bit          quiet_recv = 1'b0;
   int          cycle_count = 0;
   int          error_count = 0;
   int          results_checked = 0;
   int          streams_sent = 0;
   int          bytes_sent = 0;
   int          limit_writes = 0;

   archive_container_validator dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_data_byte    (req_data_byte),
      .req_last_byte    (req_last_byte),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_stream_ok    (rsp_stream_ok),
      .rsp_error_class  (rsp_error_class),
      .rsp_entries_seen (rsp_entries_seen),
      .csr_wr_en        (csr_wr_en),
      .csr_wr_data      (csr_wr_data)
   );

   initial begin
      forever #6 clock = ~clock;
   end

   // ------------------------------------------------------------------------
   // framing predictor
   // ------------------------------------------------------------------------

   // stream state back to its start, version limit kept
   function automatic void clear_frame();
      seg = IN_FILE_HDR;
      hdr_pos = 0;
      ver_acc = '0;
      name_open = 1'b0;
      ehdr_pos = 0;
      size_acc = '0;
      data_left = '0;
      err_code = ERR_NONE;
      entry_cnt = '0;
   endfunction

   function automatic void close_entry();
      if (entry_cnt != '1) begin
         entry_cnt = entry_cnt + 1'b1;
      end
      seg = IN_NAME;
      name_open = 1'b0;
   endfunction

   // advance the framing state by one byte, queue a verdict on the last one
   function automatic void track_frame(input logic [7:0] b, input logic fin);
      result_type verdict;
      logic [2:0] cls;
      if (err_code == ERR_NONE) begin
         case (seg)
            IN_FILE_HDR: begin
               if (hdr_pos < MAGIC_LEN) begin
                  if (b != SIG_TEXT[hdr_pos]) begin
                     err_code = ERR_HEADER;
                  end
               end else if (hdr_pos < MAGIC_LEN + 4) begin
                  ver_acc = ver_acc | (32'(b) << (8 * (hdr_pos - MAGIC_LEN)));
               end
               if (err_code == ERR_NONE) begin
                  if (hdr_pos >= FILE_HDR_LEN - 1) begin
                     if (ver_acc > ver_limit) begin
                        err_code = ERR_VERSION;
                     end else begin
                        seg = IN_NAME;
                        name_open = 1'b0;
                     end
                  end else begin
                     hdr_pos = hdr_pos + 1;
                  end
               end
            end
            IN_NAME: begin
               if (b == LINE_FEED) begin
                  if (!name_open) begin
                     err_code = ERR_ENTRY;
                  end else begin
                     seg = IN_ENTRY_HDR;
                     ehdr_pos = 0;
                     size_acc = '0;
                  end
               end else begin
                  name_open = 1'b1;
               end
            end
            IN_ENTRY_HDR: begin
               // last four header bytes carry the packed size
               if (ehdr_pos >= ENTRY_HDR_LEN - 4) begin
                  size_acc = size_acc
                     | (32'(b) << (8 * (ehdr_pos - (ENTRY_HDR_LEN - 4))));
               end
               if (ehdr_pos >= ENTRY_HDR_LEN - 1) begin
                  data_left = size_acc;
                  if (data_left == 0) begin
                     close_entry();
                  end else begin
                     seg = IN_DATA;
                  end
               end else begin
                  ehdr_pos = ehdr_pos + 1;
               end
            end
            default: begin
               if (data_left > 0) begin
                  data_left = data_left - 1;
               end
               if (data_left == 0) begin
                  close_entry();
               end
            end
         endcase
      end
      if (fin) begin
         cls = err_code;
         if (cls == ERR_NONE) begin
            case (seg)
               IN_FILE_HDR:  cls = ERR_HEADER;
               IN_NAME:      cls = name_open ? ERR_ENTRY : ERR_NONE;
               IN_ENTRY_HDR: cls = ERR_ENTRY;
               default:      cls = ERR_TRUNC;
            endcase
         end
         verdict.stream_ok = (cls == ERR_NONE);
         verdict.error_class = cls;
         verdict.entries_seen = 16'(entry_cnt);
         verdict_q.push_back(verdict);
         clear_frame();
      end
   endfunction

   // ------------------------------------------------------------------------
   // verdict checking
   // ------------------------------------------------------------------------

   function automatic void flag_error(input string what, input int unsigned want,
                                      input int unsigned got);
      error_count++;
      if (error_count <= REPORT_MAX) begin
         $display("mismatch at verdict %0d: %s expected %0h got %0h",
                  results_checked, what, want, got);
      end
   endfunction

   function automatic void check_verdict();
      result_type want;
      if (verdict_q.size() == 0) begin
         flag_error("verdict with no stream end pending, class", 0, rsp_error_class);
      end else begin
         want = verdict_q.pop_front();
         if (rsp_stream_ok !== want.stream_ok) begin
            flag_error("stream_ok", want.stream_ok, rsp_stream_ok);
         end
         if (rsp_error_class !== want.error_class) begin
            flag_error("error_class", want.error_class, rsp_error_class);
         end
         if (rsp_entries_seen !== want.entries_seen) begin
            flag_error("entries_seen", want.entries_seen, rsp_entries_seen);
         end
      end
      results_checked++;
   endfunction

   // monitor: predict on each input transfer, check each result transfer
   always @(posedge clock) begin
      if (reset) begin
         req_fire <= 1'b0;
         clear_frame();
      end else begin
         req_fire <= req_valid && !req_stall;
         if (req_valid && !req_stall) begin
            track_frame(req_data_byte, req_last_byte);
         end
         if (rsp_valid && !rsp_stall) begin
            check_verdict();
         end
      end
   end

   // ------------------------------------------------------------------------
   // driver and receiver
   // ------------------------------------------------------------------------

   // mostly back to back, some short gaps, a few long ones
   function automatic int pick_gap(input bit quiet);
      int r;
      r = $urandom_range(0, 99);
      if (quiet || r < 70) begin
         return 0;
      end
      if (r < 95) begin
         return $urandom_range(1, 3);
      end
      return $urandom_range(8, 40);
   endfunction

   // request driver: a new byte once the current one has made its transfer
   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_fire) begin
         if (send_gap > 0) begin
            req_valid <= 1'b0;
            send_gap <= send_gap - 1;
         end else if (pending_q.size() > 0) begin
            next_step = pending_q.pop_front();
            req_valid <= 1'b1;
            req_data_byte <= next_step.data_byte;
            req_last_byte <= next_step.last_byte;
            send_gap <= pick_gap(quiet_send);
            if (next_step.last_byte) begin
               quiet_send <= ($urandom_range(0, 3) == 0);
            end
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // result side back-pressure
   always @(negedge clock) begin
      if (stall_left > 0) begin
         rsp_stall <= 1'b1;
         stall_left <= stall_left - 1;
      end else begin
         rsp_stall <= 1'b0;
         stall_left <= pick_gap(quiet_recv);
      end
      if ($urandom_range(0, 99) == 0) begin
         quiet_recv <= ~quiet_recv;
      end
   end

   // run limit
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= RUN_LIMIT) begin
         $display("timeout after %0d cycles, %0d verdicts outstanding",
                  cycle_count, verdict_q.size());
         $display("[archive_container_validator] ERROR");
         $finish;
      end
   end

   // ------------------------------------------------------------------------
   // stream building
   // ------------------------------------------------------------------------

   function automatic logic [7:0] name_char();
      logic [7:0] b;
      b = 8'($urandom());
      if (b == LINE_FEED) begin
         b = 8'h5F;
      end
      return b;
   endfunction

   function automatic void put_file_header(input logic [31:0] ver);
      for (int i = 0; i < MAGIC_LEN; i++) begin
         frame_buf.push_back(SIG_TEXT[i]);
      end
      for (int i = 0; i < 4; i++) begin
         frame_buf.push_back(ver[8*i +: 8]);
      end
      // timestamp is not checked
      for (int i = 0; i < FILE_HDR_LEN - MAGIC_LEN - 4; i++) begin
         frame_buf.push_back(8'($urandom()));
      end
   endfunction

   function automatic void put_entry(input int name_len, input logic [31:0] size,
                                     input int data_len);
      for (int i = 0; i < name_len; i++) begin
         frame_buf.push_back(name_char());
      end
      frame_buf.push_back(LINE_FEED);
      for (int i = 0; i < ENTRY_HDR_LEN - 4; i++) begin
         frame_buf.push_back(8'($urandom()));
      end
      for (int i = 0; i < 4; i++) begin
         frame_buf.push_back(size[8*i +: 8]);
      end
      for (int i = 0; i < data_len; i++) begin
         frame_buf.push_back(8'($urandom()));
      end
   endfunction

   function automatic void trim_frame(input int keep);
      while (frame_buf.size() > keep) begin
         void'(frame_buf.pop_back());
      end
   endfunction

   // hand the built stream to the driver, last flag on its final byte
   function automatic void ship_frame();
      step_type step;
      for (int i = 0; i < frame_buf.size(); i++) begin
         step.data_byte = frame_buf[i];
         step.last_byte = (i == frame_buf.size() - 1);
         pending_q.push_back(step);
      end
      bytes_sent += frame_buf.size();
      streams_sent++;
      frame_buf.delete();
   endfunction

   function automatic logic [31:0] allowed_version();
      int r;
      r = $urandom_range(0, 99);
      if (r < 25) begin
         return 32'h0;
      end
      if (r < 50) begin
         return ver_limit;
      end
      return 32'(64'($urandom()) % (64'(ver_limit) + 1));
   endfunction

   function automatic logic [31:0] excess_version();
      logic [31:0] v;
      v = $urandom();
      if (ver_limit == '1 || v > ver_limit) begin
         return v;
      end
      return ver_limit + 1;
   endfunction

   // one random stream: well formed, broken, too new or noise
   function automatic void make_random_frame();
      int style;
      int n_ent;
      int r;
      int name_len;
      logic [31:0] size;
      int data_len;
      int idx;
      style = $urandom_range(0, 99);
      if (style < 6) begin
         // noise, sometimes starting like a real header
         n_ent = $urandom_range(1, 30);
         for (int i = 0; i < n_ent; i++) begin
            frame_buf.push_back(8'($urandom()));
         end
         if ($urandom_range(0, 1) == 1) begin
            frame_buf[0] = SIG_TEXT[0];
         end
      end else begin
         put_file_header(style < 12 ? excess_version() : allowed_version());
         n_ent = $urandom_range(0, 4);
         for (int e = 0; e < n_ent; e++) begin
            name_len = ($urandom_range(0, 99) < 3) ? 0 : $urandom_range(1, 8);
            r = $urandom_range(0, 99);
            if (r < 15) begin
               size = 32'h0;
               data_len = 0;
            end else if (r < 95) begin
               size = $urandom_range(1, 12);
               data_len = size;
            end else begin
               size = $urandom();
               data_len = $urandom_range(0, 20);
            end
            put_entry(name_len, size, data_len);
         end
         r = $urandom_range(0, 99);
         if (r < 55) begin
            // shipped as built
         end else if (r < 80) begin
            trim_frame($urandom_range(1, frame_buf.size()));
         end else if (r < 92) begin
            idx = $urandom_range(0, frame_buf.size() - 1);
            frame_buf[idx] = frame_buf[idx] ^ (8'h01 << $urandom_range(0, 7));
         end else begin
            // unfinished name at the end
            for (int i = $urandom_range(1, 4); i > 0; i--) begin
               frame_buf.push_back(name_char());
            end
         end
      end
      ship_frame();
   endfunction

   // ------------------------------------------------------------------------
   // sequencing
   // ------------------------------------------------------------------------

   task automatic wait_idle();
      while (pending_q.size() != 0 || req_valid || verdict_q.size() != 0) begin
         @(posedge clock);
      end
      // verdict pipeline is two deep; leave margin before touching the limit
      repeat (8) @(posedge clock);
   endtask

   task automatic write_limit(input logic [31:0] value);
      @(negedge clock);
      csr_wr_en <= 1'b1;
      csr_wr_data <= value;
      @(negedge clock);
      csr_wr_en <= 1'b0;
      ver_limit = value;
      limit_writes++;
   endtask

   task automatic run_random_phase();
      int phase_bytes;
      int phase_streams;
      phase_bytes = bytes_sent;
      phase_streams = streams_sent;
      while (bytes_sent - phase_bytes < PHASE_BYTES
             || streams_sent - phase_streams < PHASE_STREAMS) begin
         make_random_frame();
      end
      wait_idle();
   endtask

   initial begin
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed streams under the reset limit of one
      // header only, no entries
      put_file_header(32'd1);
      ship_frame();
      // empty entry and a small one
      put_file_header(32'd0);
      put_entry(3, 32'd0, 0);
      put_entry(1, 32'd3, 3);
      ship_frame();
      // bad first magic byte, the rest ignored
      put_file_header(32'd1);
      frame_buf[0] = 8'h51;
      put_entry(2, 32'd0, 0);
      ship_frame();
      // bad newline closing the magic
      put_file_header(32'd0);
      frame_buf[MAGIC_LEN - 1] = 8'hFF;
      ship_frame();
      // short header with oversized version bytes
      put_file_header(32'hFFFF_FFFF);
      trim_frame(MAGIC_LEN + 2);
      ship_frame();
      // single byte stream
      frame_buf.push_back(SIG_TEXT[0]);
      ship_frame();
      // versions too new
      put_file_header(32'd2);
      put_entry(2, 32'd0, 0);
      ship_frame();
      put_file_header(32'hFFFF_FFFF);
      ship_frame();
      // empty name
      put_file_header(32'd1);
      put_entry(0, 32'd0, 0);
      ship_frame();
      // end inside a name
      put_file_header(32'd1);
      frame_buf.push_back(8'h00);
      frame_buf.push_back(8'hFF);
      ship_frame();
      // end inside an entry header
      put_file_header(32'd1);
      put_entry(4, 32'd0, 0);
      trim_frame(FILE_HDR_LEN + 5 + 6);
      ship_frame();
      // header with nonzero size just completed
      put_file_header(32'd1);
      put_entry(2, 32'd4, 0);
      ship_frame();
      // end inside data
      put_file_header(32'd1);
      put_entry(2, 32'd10, 3);
      ship_frame();
      // largest size
      put_file_header(32'd1);
      put_entry(5, 32'hFFFF_FFFF, 6);
      ship_frame();
      // error after a complete entry, trailing bytes ignored
      put_file_header(32'd0);
      put_entry(1, 32'd0, 0);
      put_entry(0, 32'd2, 2);
      put_entry(3, 32'd1, 1);
      ship_frame();
      wait_idle();

      // random streams under a series of version limits
      run_random_phase();
      write_limit(32'h0);
      run_random_phase();
      write_limit(32'hFFFF_FFFF);
      run_random_phase();
      write_limit($urandom());
      run_random_phase();
      write_limit(32'd3);
      run_random_phase();
      write_limit(MAX_VERSION_RESET);
      run_random_phase();

      $display("sent %0d streams (%0d bytes) under %0d version limit writes",
               streams_sent, bytes_sent, limit_writes);
      $display("checked %0d verdicts, %0d failures, %0d verdicts left over",
               results_checked, error_count, verdict_q.size());
      if (error_count == 0 && verdict_q.size() == 0) begin
         $display("[archive_container_validator] OK");
      end else begin
         $display("[archive_container_validator] ERROR");
      end
      $finish;
   end

endmodule
